>>> rtl/twpd_pkg.sv
// ----------------------------------------------------------------------------
// twpd_pkg
// Shared widths, codes and control types of the two-phase walk dispatcher.
// ----------------------------------------------------------------------------
package twpd_pkg;

    localparam int PW_BITS      = 16;
    localparam int SCALE_BITS   = 40;
    localparam int HIT_BITS     = 32;
    localparam int COUNT_BITS   = 40;
    localparam int SUM_BITS     = 48;
    localparam int WIDE_BITS    = 64;
    localparam int CFG_IDX_BITS = 1;
    localparam int PRELIM_LIMIT = 65535;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
    localparam logic [PW_BITS-1:0]    PW_LIMIT  = PW_BITS'(PRELIM_LIMIT);

    localparam logic FUNC_REQ = 1'b0;
    localparam logic FUNC_RET = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PRELIM = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE  = 1'b1;

    typedef struct packed {
        logic upd;
        logic div_p_start;
        logic div_e_start;
        logic sqrt_init;
        logic sqrt_step;
        logic mul_init;
        logic mul_step;
        logic fin;
        logic est_load;
        logic est_zero;
        logic emit;
    } twpd_cmd_t;

    typedef struct packed {
        logic trig;
        logic done;
        logic div_done;
        logic sqrt_last;
        logic mul_last;
    } twpd_stat_t;

endpackage

>>> rtl/twpd_in_if.sv
// ----------------------------------------------------------------------------
// twpd_in_if
// Input channel: job requests and returned walk results.
// ----------------------------------------------------------------------------
interface twpd_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic        phase_prelim;
    logic [31:0] hit_count;

    modport source (output valid, func, phase_prelim, hit_count, input ready);
    modport sink   (input valid, func, phase_prelim, hit_count, output ready);
endinterface

>>> rtl/twpd_out_if.sv
// ----------------------------------------------------------------------------
// twpd_out_if
// Output channel: one result item per input item.
// ----------------------------------------------------------------------------
interface twpd_out_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic        job_prelim;
    logic        target_known;
    logic [39:0] final_walks;
    logic [47:0] final_hits;
    logic        done_res;
    logic [47:0] estimate;

    modport source (output valid, granted, job_prelim, target_known, final_walks,
                    final_hits, done_res, estimate, input ready);
    modport sink   (input valid, granted, job_prelim, target_known, final_walks,
                    final_hits, done_res, estimate, output ready);
endinterface

>>> rtl/twpd_div.sv
// ----------------------------------------------------------------------------
// twpd_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twpd_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [twpd_pkg::WIDE_BITS-1:0]     dividend,
    input  logic [twpd_pkg::COUNT_BITS-1:0]    divisor,
    output logic [twpd_pkg::WIDE_BITS-1:0]     quotient,
    output logic                               done
);
    import twpd_pkg::*;

    localparam int CW = $clog2(WIDE_BITS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [WIDE_BITS-1:0]  quo_reg, quo_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] dsr_reg, dsr_next;
    logic [COUNT_BITS:0]   shifted;
    logic                  fits;

    // shift in one dividend bit, subtract where the divisor fits
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[WIDE_BITS-1]};
        fits      = shifted >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? COUNT_BITS'(shifted - {1'b0, dsr_reg})
                            : shifted[COUNT_BITS-1:0];
            quo_next = {quo_reg[WIDE_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WIDE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

>>> rtl/twpd_dp.sv
// ----------------------------------------------------------------------------
// twpd_dp
// Datapath: job counters, hit sums, target arithmetic and result register.
// ----------------------------------------------------------------------------
module twpd_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  twpd_pkg::twpd_cmd_t                  cmd,
    output twpd_pkg::twpd_stat_t                 stat,
    input  logic                                 func,
    input  logic                                 phase_prelim,
    input  logic [twpd_pkg::HIT_BITS-1:0]        hit_count,
    input  logic                                 cfg_we,
    input  logic [twpd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [twpd_pkg::SCALE_BITS-1:0]      cfg_wdata,
    output logic                                 granted,
    output logic                                 job_prelim,
    output logic                                 target_known,
    output logic [twpd_pkg::COUNT_BITS-1:0]      final_walks,
    output logic [twpd_pkg::SUM_BITS-1:0]        final_hits,
    output logic                                 done_res,
    output logic [twpd_pkg::SUM_BITS-1:0]        estimate
);
    import twpd_pkg::*;

    localparam int PROD_BITS = SCALE_BITS + WIDE_BITS;
    localparam int CHUNK     = 16;
    localparam int NCHUNK    = WIDE_BITS / CHUNK;
    localparam int MCW       = $clog2(NCHUNK);
    localparam int SQ_STEPS  = WIDE_BITS / 2;
    localparam int SCW       = $clog2(SQ_STEPS);

    // configuration
    logic [PW_BITS-1:0]    pw_reg, pw_next;
    logic [SCALE_BITS-1:0] scale_reg, scale_next;

    // run state
    logic [PW_BITS-1:0]    pi_reg, pi_next;
    logic [PW_BITS-1:0]    pr_reg, pr_next;
    logic [SUM_BITS-1:0]   psum_reg, psum_next;
    logic [COUNT_BITS-1:0] ft_reg, ft_next;
    logic                  tv_reg, tv_next;
    logic [COUNT_BITS-1:0] fi_reg, fi_next;
    logic [COUNT_BITS-1:0] fr_reg, fr_next;
    logic [SUM_BITS-1:0]   fsum_reg, fsum_next;

    // target arithmetic
    logic [WIDE_BITS-1:0]  p_reg, p_next;
    logic [WIDE_BITS-1:0]  sv_reg, sv_next;
    logic [WIDE_BITS-1:0]  sres_reg, sres_next;
    logic [SCW-1:0]        scnt_reg, scnt_next;
    logic [WIDE_BITS-1:0]  s_reg, s_next;
    logic [PROD_BITS-1:0]  acc_reg, acc_next;
    logic [MCW-1:0]        mcnt_reg, mcnt_next;

    // item result
    logic                  g_reg, g_next;
    logic                  jp_reg, jp_next;
    logic [SUM_BITS-1:0]   est_reg, est_next;
    logic                  o_g_reg, o_jp_reg, o_tk_reg, o_done_reg;
    logic [COUNT_BITS-1:0] o_fw_reg;
    logic [SUM_BITS-1:0]   o_fh_reg, o_est_reg;

    logic [PW_BITS-1:0]    eff;
    logic [SUM_BITS:0]     psum_add, fsum_add;
    logic                  done_now;
    logic                  div_start, div_done;
    logic [WIDE_BITS-1:0]  div_dvd, div_quo;
    logic [COUNT_BITS-1:0] div_dsr;
    logic [WIDE_BITS-1:0]  sq_bit, sq_try;
    logic [CHUNK-1:0]      s_chunk;
    logic [SCALE_BITS+CHUNK-1:0] partial;
    logic [WIDE_BITS-1:0]  q_ceil;
    logic [COUNT_BITS-1:0] t_sat, t_min;

    // effective preliminary count
    always_comb
    begin
        eff = pw_reg;
        if (pw_reg == '0)
            eff = PW_BITS'(1);
        else if (pw_reg > PW_LIMIT)
            eff = PW_LIMIT;
    end

    assign psum_add = {1'b0, psum_reg} + {{(SUM_BITS-HIT_BITS+1){1'b0}}, hit_count};
    assign fsum_add = {1'b0, fsum_reg} + {{(SUM_BITS-HIT_BITS+1){1'b0}}, hit_count};
    assign done_now = tv_reg && (fr_reg >= ft_reg);

    // shared divider: preliminary mean, or final estimate
    assign div_start = cmd.div_p_start | cmd.div_e_start;
    assign div_dvd   = cmd.div_e_start ? {fsum_reg, {(WIDE_BITS-SUM_BITS){1'b0}}}
                                       : {psum_reg, {(WIDE_BITS-SUM_BITS){1'b0}}};
    assign div_dsr   = cmd.div_e_start ? ft_reg
                                       : {{(COUNT_BITS-PW_BITS){1'b0}}, eff};

    twpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quotient (div_quo),
        .done     (div_done)
    );

    // square root step, target product step and final rounding
    assign sq_bit  = WIDE_BITS'(1) << {scnt_reg, 1'b0};
    assign sq_try  = sres_reg + sq_bit;
    assign s_chunk = s_reg[mcnt_reg*CHUNK +: CHUNK];
    assign partial = scale_reg * s_chunk;
    assign q_ceil  = acc_reg[WIDE_BITS+31:32] + {{(WIDE_BITS-1){1'b0}}, |acc_reg[31:0]};
    assign t_sat   = (q_ceil > {{(WIDE_BITS-COUNT_BITS){1'b0}}, COUNT_MAX})
                     ? COUNT_MAX : q_ceil[COUNT_BITS-1:0];
    assign t_min   = (t_sat == '0) ? COUNT_BITS'(1) : t_sat;

    always_comb
    begin
        pw_next    = pw_reg;
        scale_next = scale_reg;
        pi_next    = pi_reg;
        pr_next    = pr_reg;
        psum_next  = psum_reg;
        ft_next    = ft_reg;
        tv_next    = tv_reg;
        fi_next    = fi_reg;
        fr_next    = fr_reg;
        fsum_next  = fsum_reg;
        p_next     = p_reg;
        sv_next    = sv_reg;
        sres_next  = sres_reg;
        scnt_next  = scnt_reg;
        s_next     = s_reg;
        acc_next   = acc_reg;
        mcnt_next  = mcnt_reg;
        g_next     = g_reg;
        jp_next    = jp_reg;
        est_next   = est_reg;

        // write a register
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRELIM: pw_next    = cfg_wdata[PW_BITS-1:0];
                CFG_SCALE:  scale_next = cfg_wdata;
                default:    ;
            endcase
        end

        // apply one item to the counters and sums
        if (cmd.upd)
        begin
            g_next  = 1'b0;
            jp_next = 1'b0;
            if (func == FUNC_REQ)
            begin
                if (pi_reg < eff)
                begin
                    pi_next = pi_reg + 1'b1;
                    g_next  = 1'b1;
                    jp_next = 1'b1;
                end
                else if (fi_reg < COUNT_MAX && (!tv_reg || fi_reg < ft_reg))
                begin
                    fi_next = fi_reg + 1'b1;
                    g_next  = 1'b1;
                end
            end
            else if (phase_prelim)
            begin
                if (!tv_reg && pr_reg < eff)
                begin
                    pr_next   = pr_reg + 1'b1;
                    psum_next = psum_add[SUM_BITS] ? SUM_MAX : psum_add[SUM_BITS-1:0];
                end
            end
            else
            begin
                if (fr_reg != COUNT_MAX)
                    fr_next = fr_reg + 1'b1;
                fsum_next = fsum_add[SUM_BITS] ? SUM_MAX : fsum_add[SUM_BITS-1:0];
            end
        end

        // load the mean and seed the square root of mean * 2^16
        if (cmd.sqrt_init)
        begin
            p_next    = div_quo;
            sv_next   = {div_quo[WIDE_BITS-17:0], 16'b0};
            sres_next = '0;
            scnt_next = SCW'(SQ_STEPS - 1);
        end

        if (cmd.sqrt_step)
        begin
            if (sv_reg >= sq_try)
            begin
                sv_next   = sv_reg - sq_try;
                sres_next = (sres_reg >> 1) + sq_bit;
            end
            else
                sres_next = sres_reg >> 1;
            scnt_next = scnt_reg - 1'b1;
        end

        // form mean + root + 2 and clear the product
        if (cmd.mul_init)
        begin
            s_next    = p_reg + sres_reg + (WIDE_BITS'(2) << 16);
            acc_next  = '0;
            mcnt_next = '0;
        end

        if (cmd.mul_step)
        begin
            acc_next  = acc_reg + ({{(PROD_BITS-SCALE_BITS-CHUNK){1'b0}}, partial}
                                   << (mcnt_reg * CHUNK));
            mcnt_next = mcnt_reg + 1'b1;
        end

        // round up, clamp and raise to the jobs already out
        if (cmd.fin)
        begin
            ft_next = (t_min < fi_reg) ? fi_reg : t_min;
            tv_next = 1'b1;
        end

        if (cmd.est_load)
            est_next = (div_quo[WIDE_BITS-1:SUM_BITS] != '0) ? SUM_MAX
                                                             : div_quo[SUM_BITS-1:0];
        if (cmd.est_zero)
            est_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg    <= PW_BITS'(1);
            scale_reg <= '0;
            pi_reg    <= '0;
            pr_reg    <= '0;
            psum_reg  <= '0;
            ft_reg    <= '0;
            tv_reg    <= 1'b0;
            fi_reg    <= '0;
            fr_reg    <= '0;
            fsum_reg  <= '0;
        end
        else
        begin
            pw_reg    <= pw_next;
            scale_reg <= scale_next;
            pi_reg    <= pi_next;
            pr_reg    <= pr_next;
            psum_reg  <= psum_next;
            ft_reg    <= ft_next;
            tv_reg    <= tv_next;
            fi_reg    <= fi_next;
            fr_reg    <= fr_next;
            fsum_reg  <= fsum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        sv_reg   <= sv_next;
        sres_reg <= sres_next;
        scnt_reg <= scnt_next;
        s_reg    <= s_next;
        acc_reg  <= acc_next;
        mcnt_reg <= mcnt_next;
        g_reg    <= g_next;
        jp_reg   <= jp_next;
        est_reg  <= est_next;
    end

    // capture the result item
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_g_reg    <= g_reg;
            o_jp_reg   <= jp_reg;
            o_tk_reg   <= tv_reg;
            o_fw_reg   <= tv_reg ? ft_reg : '0;
            o_fh_reg   <= fsum_reg;
            o_done_reg <= done_now;
            o_est_reg  <= est_reg;
        end
    end

    assign stat.trig      = (func == FUNC_RET) && phase_prelim && !tv_reg &&
                            (pr_reg < eff) && ((pr_reg + 1'b1) == eff);
    assign stat.done      = done_now;
    assign stat.div_done  = div_done;
    assign stat.sqrt_last = (scnt_reg == '0);
    assign stat.mul_last  = (mcnt_reg == MCW'(NCHUNK - 1));

    assign granted      = o_g_reg;
    assign job_prelim   = o_jp_reg;
    assign target_known = o_tk_reg;
    assign final_walks  = o_fw_reg;
    assign final_hits   = o_fh_reg;
    assign done_res     = o_done_reg;
    assign estimate     = o_est_reg;
endmodule

>>> rtl/twpd_ctrl.sv
// ----------------------------------------------------------------------------
// twpd_ctrl
// Controller: sequences one item through update, target and estimate.
// ----------------------------------------------------------------------------
module twpd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output twpd_pkg::twpd_cmd_t   cmd,
    input  twpd_pkg::twpd_stat_t  stat
);
    import twpd_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TDIV   = 4'd1;
    localparam logic [3:0] S_TWAIT  = 4'd2;
    localparam logic [3:0] S_SQRT   = 4'd3;
    localparam logic [3:0] S_MULI   = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_FIN    = 4'd6;
    localparam logic [3:0] S_CHECK  = 4'd7;
    localparam logic [3:0] S_EWAIT  = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.upd    = 1'b1;
                    state_next = stat.trig ? S_TDIV : S_CHECK;
                end
            end
            S_TDIV:
            begin
                cmd.div_p_start = 1'b1;
                state_next      = S_TWAIT;
            end
            S_TWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                    state_next = S_MULI;
            end
            S_MULI:
            begin
                cmd.mul_init = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.done)
                begin
                    cmd.div_e_start = 1'b1;
                    state_next      = S_EWAIT;
                end
                else
                begin
                    cmd.est_zero = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_EWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.est_load = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!ov_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // output valid: set on capture, drop when taken
    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (cmd.emit)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
endmodule

>>> rtl/two_phase_walk_job_dispatcher.sv
// ----------------------------------------------------------------------------
// two_phase_walk_job_dispatcher
// Hands out preliminary and final walk jobs, sums returned hits, sets the
// final walk target and reports the Q32.16 estimate.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        func, phase_prelim, hit_count
//   out_ch    out  valid/ready        granted, job_prelim, target_known,
//                                     final_walks, final_hits, done_res, estimate
//   cfg       in   cfg_we             cfg_index, cfg_wdata
//
// An accepted item passes the check and emit states before its result is
// registered; the next item is accepted after that. The item that
// closes the preliminary phase also sets the target (64-step divider, 32-step
// square root, 4-step product). Once all final results are back, every item
// also runs the estimate division on the same divider.
// One item is in work at a time; a waiting result does not block acceptance.
// Reset clears all job counters, sums and the target; no clearing pass.
// ----------------------------------------------------------------------------
module two_phase_walk_job_dispatcher (
    input  logic                                clk,
    input  logic                                rst_n,
    twpd_in_if.sink                             in_ch,
    twpd_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [twpd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [twpd_pkg::SCALE_BITS-1:0]     cfg_wdata
);
    import twpd_pkg::*;

    twpd_cmd_t  cmd;
    twpd_stat_t stat;

    twpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    twpd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .func         (in_ch.func),
        .phase_prelim (in_ch.phase_prelim),
        .hit_count    (in_ch.hit_count),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .granted      (out_ch.granted),
        .job_prelim   (out_ch.job_prelim),
        .target_known (out_ch.target_known),
        .final_walks  (out_ch.final_walks),
        .final_hits   (out_ch.final_hits),
        .done_res     (out_ch.done_res),
        .estimate     (out_ch.estimate)
    );
endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-phase walk job dispatcher. Items are
// queued by a stimulus process, sent by a clocked driver with random gaps,
// and every result is checked field by field against a cycle-free predictor
// of the grant, summing and target logic.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import twpd_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 250;

    typedef struct {
        logic        func;
        logic        phase_prelim;
        logic [31:0] hit_count;
    } walk_item_t;

    typedef struct {
        logic        granted;
        logic        job_prelim;
        logic        target_known;
        logic [39:0] final_walks;
        logic [47:0] final_hits;
        logic        done_res;
        logic [47:0] estimate;
    } walk_status_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [SCALE_BITS-1:0]   cfg_wdata;

    twpd_in_if  in_ch ();
    twpd_out_if out_ch ();

    two_phase_walk_job_dispatcher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    walk_item_t   pending_items[$];
    walk_status_t status_due[$];
    int           errors;
    int           cycles;
    bit           run_on;
    int           send_gap;
    int           recv_gap;

    // predictor copy of configuration and state
    logic [PW_BITS-1:0]    m_prelim_walks;
    logic [SCALE_BITS-1:0] m_final_scale;
    logic [15:0]           m_prelim_issued;
    logic [15:0]           m_prelim_returned;
    logic [47:0]           m_prelim_sum;
    logic [39:0]           m_target;
    logic                  m_target_valid;
    logic [39:0]           m_final_issued;
    logic [39:0]           m_final_returned;
    logic [47:0]           m_final_sum;

    function automatic logic [63:0] eff_walks();
        logic [63:0] p;
        p = 64'(m_prelim_walks);
        if (p == 0) p = 1;
        if (p > PRELIM_LIMIT) p = PRELIM_LIMIT;
        return p;
    endfunction

    function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] lim);
        if (a >= lim || b > lim - a) return lim;
        return a + b;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt = 64'h1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return res;
    endfunction

    // set the final walk target from the preliminary hit mean
    function automatic void settle_target();
        logic [63:0] p, sq, s, a, a_lo, a_hi, b_lo, b_hi, ll, q, t;
        p = (64'(m_prelim_sum) << 16) / eff_walks();
        sq = int_sqrt(p << 16);
        s = p + sq + (64'd2 << 16);
        a = 64'(m_final_scale);
        a_lo = {32'd0, a[31:0]};
        a_hi = a >> 32;
        b_lo = {32'd0, s[31:0]};
        b_hi = s >> 32;
        ll = a_lo * b_lo;
        q = (ll >> 32) + a_lo * b_hi + a_hi * b_lo + ((a_hi * b_hi) << 32);
        if (ll[31:0] != 0) q = q + 1;
        t = (q > 64'(COUNT_MAX)) ? 64'(COUNT_MAX) : q;
        if (t < 1) t = 1;
        if (t < 64'(m_final_issued)) t = 64'(m_final_issued);
        m_target = t[39:0];
        m_target_valid = 1'b1;
    endfunction

    // advance the predictor by one item and return the status it yields
    function automatic walk_status_t dispatch_step(walk_item_t it);
        walk_status_t r;
        logic [63:0]  e;
        r = '{default: '0};
        if (it.func == FUNC_REQ)
        begin
            if (64'(m_prelim_issued) < eff_walks())
            begin
                m_prelim_issued = m_prelim_issued + 1'b1;
                r.granted = 1'b1;
                r.job_prelim = 1'b1;
            end
            else if (m_final_issued < COUNT_MAX &&
                     (!m_target_valid || m_final_issued < m_target))
            begin
                m_final_issued = m_final_issued + 1'b1;
                r.granted = 1'b1;
            end
        end
        else if (it.phase_prelim)
        begin
            if (!m_target_valid && 64'(m_prelim_returned) < eff_walks())
            begin
                m_prelim_returned = m_prelim_returned + 1'b1;
                m_prelim_sum = 48'(add_clip(64'(m_prelim_sum), 64'(it.hit_count),
                                            64'(SUM_MAX)));
                if (64'(m_prelim_returned) == eff_walks()) settle_target();
            end
        end
        else
        begin
            m_final_returned = 40'(add_clip(64'(m_final_returned), 1, 64'(COUNT_MAX)));
            m_final_sum = 48'(add_clip(64'(m_final_sum), 64'(it.hit_count),
                                       64'(SUM_MAX)));
        end
        if (m_target_valid && m_final_returned >= m_target)
        begin
            r.done_res = 1'b1;
            e = (64'(m_final_sum) << 16) / 64'(m_target);
            if (e > 64'(SUM_MAX)) e = 64'(SUM_MAX);
            r.estimate = e[47:0];
        end
        r.target_known = m_target_valid;
        r.final_walks = m_target_valid ? m_target : '0;
        r.final_hits = m_final_sum;
        return r;
    endfunction

    function automatic int draw_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 14);
    endfunction

    task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            errors++;
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_ch.valid || status_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data[SCALE_BITS-1:0];
        if (idx == CFG_PRELIM) m_prelim_walks = data[PW_BITS-1:0];
        else m_final_scale = data[SCALE_BITS-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_item(logic f, logic ph, logic [31:0] h);
        walk_item_t it;
        it.func = f;
        it.phase_prelim = ph;
        it.hit_count = h;
        pending_items.push_back(it);
    endtask

    // queue one random item; prelim hits stay small unless asked otherwise
    task automatic push_random(bit wide_prelim);
        int          k;
        logic [31:0] h;
        k = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0: h = 32'hFFFF_FFFF;
            1: h = $urandom();
            default: h = $urandom_range(0, 3);
        endcase
        if (k < 45) push_item(FUNC_REQ, 1'($urandom_range(0, 1)), $urandom());
        else if (k < 70) push_item(FUNC_RET, 1'b1, wide_prelim ? h : $urandom_range(0, 3));
        else push_item(FUNC_RET, 1'b0, h);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // driver: send queued items, pick a gap for each
    always @(posedge clk)
    begin
        logic       v;
        walk_item_t it;
        v = in_ch.valid;
        if (in_ch.valid && in_ch.ready)
        begin
            it.func = in_ch.func;
            it.phase_prelim = in_ch.phase_prelim;
            it.hit_count = in_ch.hit_count;
            status_due.push_back(dispatch_step(it));
            v = 1'b0;
        end
        if (!v && run_on)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                in_ch.func <= it.func;
                in_ch.phase_prelim <= it.phase_prelim;
                in_ch.hit_count <= it.hit_count;
                v = 1'b1;
                send_gap = draw_gap();
            end
        end
        in_ch.valid <= v;
    end

    // monitor: check each result item, stall at random
    always @(posedge clk)
    begin
        logic         r;
        walk_status_t e;
        r = out_ch.ready;
        if (out_ch.valid && out_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                $display("%0t: unexpected result item, actual hits %0h", $time,
                         out_ch.final_hits);
                errors++;
            end
            else
            begin
                e = status_due.pop_front();
                check_field("granted", 64'(e.granted), 64'(out_ch.granted));
                check_field("job_prelim", 64'(e.job_prelim), 64'(out_ch.job_prelim));
                check_field("target_known", 64'(e.target_known),
                            64'(out_ch.target_known));
                check_field("final_walks", 64'(e.final_walks), 64'(out_ch.final_walks));
                check_field("final_hits", 64'(e.final_hits), 64'(out_ch.final_hits));
                check_field("done_res", 64'(e.done_res), 64'(out_ch.done_res));
                check_field("estimate", 64'(e.estimate), 64'(out_ch.estimate));
            end
            r = 1'b0;
            recv_gap = draw_gap();
        end
        if (!r && run_on)
        begin
            if (recv_gap > 0) recv_gap--;
            else r = 1'b1;
        end
        out_ch.ready <= r;
    end

    // stimulus
    initial
    begin
        errors = 0;
        cycles = 0;
        run_on = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_REQ;
        in_ch.phase_prelim = 1'b0;
        in_ch.hit_count = '0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PRELIM;
        cfg_wdata = '0;
        m_prelim_walks = 1;
        m_final_scale = '0;
        m_prelim_issued = '0;
        m_prelim_returned = '0;
        m_prelim_sum = '0;
        m_target = '0;
        m_target_valid = 1'b0;
        m_final_issued = '0;
        m_final_returned = '0;
        m_final_sum = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero preliminary count acts as one: one prelim job, then unlimited finals
        write_reg(CFG_PRELIM, 0);
        run_on = 1'b1;
        push_item(FUNC_REQ, 1'b0, 32'hFFFF_FFFF);
        push_item(FUNC_REQ, 1'b1, 32'h0);
        push_item(FUNC_REQ, 1'b0, 32'h0);
        push_item(FUNC_REQ, 1'b0, 32'h0);
        push_item(FUNC_RET, 1'b0, 32'hFFFF_FFFF);
        push_item(FUNC_RET, 1'b0, 32'h0);
        push_item(FUNC_RET, 1'b0, 32'h5555_AAAA);
        push_item(FUNC_RET, 1'b0, 32'hAAAA_5555);
        wait_idle();

        // largest preliminary count and scale, a few prelim returns
        write_reg(CFG_PRELIM, PRELIM_LIMIT);
        write_reg(CFG_SCALE, 64'(COUNT_MAX));
        push_item(FUNC_REQ, 1'b0, 32'h0);
        push_item(FUNC_REQ, 1'b0, 32'h0);
        push_item(FUNC_RET, 1'b1, 32'h0);
        push_item(FUNC_RET, 1'b1, 32'h3);
        push_item(FUNC_RET, 1'b0, 32'hFFFF_FFFF);
        wait_idle();

        // shrink the count to 6, close the phase at unit scale
        write_reg(CFG_PRELIM, 6);
        write_reg(CFG_SCALE, 64'h1_0000);
        push_item(FUNC_RET, 1'b1, 32'h1);
        push_item(FUNC_RET, 1'b1, 32'h2);
        push_item(FUNC_RET, 1'b1, 32'h0);
        push_item(FUNC_RET, 1'b1, 32'h1);
        // extra prelim return once the target is known
        push_item(FUNC_RET, 1'b1, 32'hFFFF_FFFF);
        push_item(FUNC_REQ, 1'b0, 32'h0);
        push_item(FUNC_REQ, 1'b0, 32'h0);
        push_item(FUNC_RET, 1'b0, 32'h7);
        wait_idle();

        // random phases with fresh settings between them
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_reg(CFG_PRELIM, 64'd65535);
                1: write_reg(CFG_PRELIM, 64'd0);
                default: write_reg(CFG_PRELIM, 64'($urandom_range(0, 65535)));
            endcase
            case (ph)
                0: write_reg(CFG_SCALE, 64'd0);
                1: write_reg(CFG_SCALE, 64'(COUNT_MAX));
                default: write_reg(CFG_SCALE, {$urandom_range(0, 255), $urandom()});
            endcase
            for (int i = 0; i < 410; i++)
                push_random(1'b1);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && status_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
